// ===== rtl/tnsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tnsc_pkg
// Shared types and constants of the three-register nibble stream cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tnsc_pkg;

  localparam int MAX_REPEAT = 15;
  localparam int CNT_W      = $clog2(MAX_REPEAT + 1);

  localparam int LEFT_W   = 35;
  localparam int MIDDLE_W = 49;
  localparam int RIGHT_W  = 25;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_FEEDBACK = 1'b0;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_SHIFT   = 3'd1,
    ACT_SECURE  = 3'd2,
    ACT_ENCRYPT = 3'd3,
    ACT_DECRYPT = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    IN_ZERO = 2'd0,
    IN_DATA = 2'd1,
    IN_RES  = 2'd2
  } in_sel_e;

  typedef enum logic [1:0] {
    OUT_KS  = 2'd0,
    OUT_SEC = 2'd1,
    OUT_RES = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     round;
    logic     fb;
    in_sel_e  in_sel;
    logic     cap_hi;
    out_sel_e out_sel;
    logic     load_out;
  } tnsc_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tnsc_dp.sv =====
// ----------------------------------------------------------------------------
// tnsc_dp
// Cipher datapath: left, middle and right registers, nibble history, one
// round per cycle, operand and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnsc_dp
  import tnsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tnsc_cmd_t  cmd_i,
  input  wire logic [7:0] data_byte_i,
  output logic      [7:0] result_byte_o
);

  logic [LEFT_W-1:0]   left_q, left_d, left_x;
  logic [MIDDLE_W-1:0] mid_q, mid_d, mid_x;
  logic [RIGHT_W-1:0]  right_q, right_d, right_x;
  logic [3:0]          older_q, older_d, newer_q, newer_d;
  logic [7:0]          data_q, res_q, res_d, out_q, out_d;
  logic [7:0]          ks, a;
  logic [4:0]          l3, l6, lx, r16, r18, rx;
  logic [6:0]          m12, m13, mx;
  logic [5:0]          l_sum, r_sum;
  logic [7:0]          m_sum;
  logic [3:0]          out_l, out_r, sel, nib;

  assign ks = {older_q, newer_q};

  always_comb begin
    case (cmd_i.in_sel)
      IN_DATA: a = data_q;
      IN_RES:  a = res_q;
      default: a = 8'h00;
    endcase
    if (cmd_i.fb) begin
      a = a ^ ks;
    end

    left_x  = left_q ^ {10'b0, a[4:0], 20'b0};
    mid_x   = mid_q ^ {28'b0, a[3:0], a[7:5], 14'b0};
    right_x = right_q ^ {5'b0, a[7:3], 15'b0};

    l3    = left_x[19:15];
    l6    = left_x[4:0];
    l_sum = {1'b0, l3} + {1'b0, l6[3:0], l6[4]};
    lx    = (l_sum > 6'd31) ? 5'(l_sum - 6'd31) : l_sum[4:0];

    m12   = mid_x[13:7];
    m13   = mid_x[6:0];
    m_sum = {1'b0, m12} + {1'b0, m13[5:0], m13[6]};
    mx    = (m_sum > 8'd127) ? 7'(m_sum - 8'd127) : m_sum[6:0];

    r16   = right_x[14:10];
    r18   = right_x[4:0];
    r_sum = {1'b0, r18} + {1'b0, r16};
    rx    = (r_sum > 6'd31) ? 5'(r_sum - 6'd31) : r_sum[4:0];

    out_l = lx[3:0] ^ l3[3:0];
    out_r = rx[3:0] ^ r16[3:0];
    sel   = mx[3:0];
    nib   = (out_l & ~sel) | (out_r & sel);
  end

  always_comb begin
    left_d  = left_q;
    mid_d   = mid_q;
    right_d = right_q;
    older_d = older_q;
    newer_d = newer_q;
    if (cmd_i.clear) begin
      left_d  = '0;
      mid_d   = '0;
      right_d = '0;
      older_d = '0;
      newer_d = '0;
    end else if (cmd_i.round) begin
      left_d  = {lx, left_x[LEFT_W-1:5]};
      mid_d   = {mx, mid_x[MIDDLE_W-1:7]};
      right_d = {rx, right_x[RIGHT_W-1:5]};
      older_d = newer_q;
      newer_d = nib;
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.load) begin
      res_d = data_byte_i ^ ks;
    end else if (cmd_i.cap_hi) begin
      res_d = {nib, res_q[3:0]};
    end
    case (cmd_i.out_sel)
      OUT_SEC: out_d = {res_q[7:4], newer_q};
      OUT_RES: out_d = res_q;
      default: out_d = ks;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      mid_q   <= '0;
      right_q <= '0;
      older_q <= '0;
      newer_q <= '0;
    end else begin
      left_q  <= left_d;
      mid_q   <= mid_d;
      right_q <= right_d;
      older_q <= older_d;
      newer_q <= newer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q <= data_byte_i;
    end
    res_q <= res_d;
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign result_byte_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/tnsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnsc_ctrl
// Sequencer: decodes the action, counts rounds and hands the result word
// to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnsc_ctrl
  import tnsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic [3:0] repeat_count_i,
  input  wire logic       feedback_enable_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output tnsc_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    MODE_SHIFT = 2'd0,
    MODE_SEC   = 2'd1,
    MODE_CIPH  = 2'd2
  } mode_e;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] idx_q, idx_d, last_q, last_d, count_sat;
  logic             fb_q, fb_d, dec_q, dec_d, out_valid_q, out_valid_d;

  assign count_sat = (CNT_W'(repeat_count_i) > CNT_W'(MAX_REPEAT)) ?
                     CNT_W'(MAX_REPEAT) : CNT_W'(repeat_count_i);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    last_d      = last_q;
    fb_d        = fb_q;
    dec_d       = dec_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          mode_d     = MODE_SHIFT;
          state_d    = ST_DONE;
          unique case (action_i)
            ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            ACT_SHIFT: begin
              fb_d = feedback_enable_i;
              if (count_sat != '0) begin
                last_d  = count_sat - CNT_W'(1);
                state_d = ST_RUN;
              end
            end
            ACT_SECURE: begin
              fb_d    = 1'b0;
              mode_d  = MODE_SEC;
              last_d  = CNT_W'(3);
              state_d = ST_RUN;
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
              fb_d    = 1'b1;
              dec_d   = (action_i == ACT_DECRYPT);
              mode_d  = MODE_CIPH;
              last_d  = CNT_W'(5);
              state_d = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        cmd_o.fb    = fb_q;
        case (mode_q)
          MODE_SHIFT: cmd_o.in_sel = IN_DATA;
          MODE_CIPH: begin
            if (idx_q == '0) begin
              cmd_o.in_sel = dec_q ? IN_RES : IN_DATA;
            end else begin
              cmd_o.in_sel = IN_ZERO;
            end
          end
          default: cmd_o.in_sel = IN_ZERO;
        endcase
        cmd_o.cap_hi = (mode_q == MODE_SEC) && (idx_q == CNT_W'(1));
        idx_d        = idx_q + CNT_W'(1);
        if (idx_q == last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        case (mode_q)
          MODE_SEC:  cmd_o.out_sel = OUT_SEC;
          MODE_CIPH: cmd_o.out_sel = OUT_RES;
          default:   cmd_o.out_sel = OUT_KS;
        endcase
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SHIFT;
      idx_q       <= '0;
      last_q      <= '0;
      fb_q        <= 1'b0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      fb_q        <= fb_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/three_register_nibble_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// three_register_nibble_stream_cipher
// Nibble stream cipher core with three end-around-add shift registers.
//
// Input channel (in_valid_i / in_stall_o) takes one word: action, data byte
// and repeat count. Output channel (out_valid_o / out_stall_i) returns one
// result byte per input word, in order.
// The core runs one cipher round per cycle in a shared round unit. The round
// count is 0 for clear and unknown actions, the saturated repeat count for
// shift, 4 for a secure keystream byte and 6 for encrypt or decrypt. The next
// word is taken once the result is in the output register.
// A result held by a stalled receiver does not block the next word; only
// a second finished result waits for the output register to free up.
// Reset clears all cipher state and sets feedback_enable (APB register 0)
// to 1. Write it only while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_register_nibble_stream_cipher
  import tnsc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            action_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic [3:0]            repeat_count_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [7:0]            result_byte_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  tnsc_cmd_t cmd;
  logic      fb_en_q, fb_en_d;
  logic      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];

  always_comb begin
    fb_en_d = fb_en_q;
    if (psel && penable && pwrite && (reg_idx == REG_FEEDBACK)) begin
      fb_en_d = pwdata[0];
    end
    prdata = '0;
    if (reg_idx == REG_FEEDBACK) begin
      prdata = {{(APB_DATA_W-1){1'b0}}, fb_en_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_en_q <= 1'b1;
    end else begin
      fb_en_q <= fb_en_d;
    end
  end

  tnsc_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .repeat_count_i    (repeat_count_i),
    .feedback_enable_i (fb_en_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cmd_o             (cmd)
  );

  tnsc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .result_byte_o (result_byte_o)
  );

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous word in progress");

  // output register never overwritten while its word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  // rounds only run while input is closed
  a_round_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> (in_stall_o && !cmd.load && !cmd.clear))
    else $error("round issued while accepting a word");

endmodule

`default_nettype wire

// ===== tb/three_register_nibble_stream_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// three_register_nibble_stream_cipher_tb
// Self-checking testbench for the nibble stream cipher core.
//
// A driver feeds action words from a queue with bursts and gaps. A receiver
// stalls the result channel on changing patterns and holds off once in a
// while for a long stretch. Every accepted word runs through a cycle-free
// model of the three cipher registers. The expected result byte is queued
// and compared in order with each result that the core hands over. The
// feedback register is written over the APB port between phases, while the
// core is idle, and read back. The first words aim at the corner cases; the
// rest are random sessions and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_register_nibble_stream_cipher_tb;
  import tnsc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 325;
  localparam logic [APB_ADDR_W-1:0] FEEDBACK_ADDR = APB_ADDR_W'(4 * int'(REG_FEEDBACK));

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic [3:0] count;
  } cmd_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [2:0]            action       = '0;
  logic [7:0]            data_byte    = '0;
  logic [3:0]            repeat_count = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [7:0]            result_byte;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cmd_word_t  word_queue[$];
  logic [7:0] result_bytes_due[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         got_count   = 0;

  // model of the cipher state
  logic [LEFT_W-1:0]   left_reg   = '0;
  logic [MIDDLE_W-1:0] middle_reg = '0;
  logic [RIGHT_W-1:0]  right_reg  = '0;
  logic [3:0]          ks_old     = '0;
  logic [3:0]          ks_new     = '0;
  logic                fb_en      = 1'b1;

  three_register_nibble_stream_cipher u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .data_byte_i    (data_byte),
    .repeat_count_i (repeat_count),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_byte_o  (result_byte),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // end-around reduction
  function automatic int unsigned fold_mod(input int unsigned s, input int unsigned m);
    if (s < m) return s;
    return (s % m == 0) ? m : s % m;
  endfunction

  function automatic void cipher_round(input logic fb, input logic [7:0] din);
    logic [7:0] a;
    logic [4:0] l3, l6, lx, r16, r18, rx;
    logic [6:0] m12, m13, mx;
    logic [3:0] out_l, out_r, sel;
    a = din;
    if (fb) a ^= {ks_old, ks_new};

    left_reg[24:20] ^= a[4:0];
    l3 = left_reg[19:15];
    l6 = left_reg[4:0];
    lx = 5'(fold_mod(int'(l3) + int'({l6[3:0], l6[4]}), 31));
    left_reg = {lx, left_reg[LEFT_W-1:5]};
    out_l = lx[3:0] ^ l3[3:0];

    middle_reg[20:14] ^= {a[3:0], a[7:5]};
    m12 = middle_reg[13:7];
    m13 = middle_reg[6:0];
    mx = 7'(fold_mod(int'(m12) + int'({m13[5:0], m13[6]}), 127));
    middle_reg = {mx, middle_reg[MIDDLE_W-1:7]};
    sel = mx[3:0];

    right_reg[19:15] ^= a[7:3];
    r16 = right_reg[14:10];
    r18 = right_reg[4:0];
    rx = 5'(fold_mod(int'(r18) + int'(r16), 31));
    right_reg = {rx, right_reg[RIGHT_W-1:5]};
    out_r = rx[3:0] ^ r16[3:0];

    ks_old = ks_new;
    ks_new = (out_l & ~sel) | (out_r & sel);
  endfunction

  function automatic logic [7:0] cipher_step(input cmd_word_t w);
    logic [7:0] res;
    int         n;
    case (w.action)
      ACT_CLEAR: begin
        left_reg   = '0;
        middle_reg = '0;
        right_reg  = '0;
        ks_old     = '0;
        ks_new     = '0;
        res        = {ks_old, ks_new};
      end
      ACT_SHIFT: begin
        n = (int'(w.count) > MAX_REPEAT) ? MAX_REPEAT : int'(w.count);
        for (int i = 0; i < n; i++) cipher_round(fb_en, w.data);
        res = {ks_old, ks_new};
      end
      ACT_SECURE: begin
        cipher_round(1'b0, 8'h00);
        cipher_round(1'b0, 8'h00);
        res[7:4] = ks_new;
        cipher_round(1'b0, 8'h00);
        cipher_round(1'b0, 8'h00);
        res[3:0] = ks_new;
      end
      ACT_ENCRYPT, ACT_DECRYPT: begin
        res = w.data ^ {ks_old, ks_new};
        cipher_round(1'b1, (w.action == ACT_DECRYPT) ? res : w.data);
        for (int i = 0; i < 5; i++) cipher_round(1'b1, 8'h00);
      end
      default: res = {ks_old, ks_new};
    endcase
    return res;
  endfunction

  // driver
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    cmd_word_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_bytes_due.push_back(cipher_step('{action, data_byte, repeat_count}));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          nxt = word_queue.pop_front();
          action       <= nxt.action;
          data_byte    <= nxt.data;
          repeat_count <= nxt.count;
          in_valid     <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern, with long hold-offs while words are still queued
  int          hold_left    = 0;
  int          next_hold_at = 100;
  int          mode_left    = 0;
  int          stall_mode   = 0;
  logic [15:0] stall_pat    = 16'h0f0f;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && word_queue.size() > 100 && got_count >= next_hold_at) begin
        hold_left    = $urandom_range(120, 200);
        next_hold_at = got_count + 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 120);
          stall_pat  = 16'($urandom);
        end
        mode_left--;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: begin
            out_stall <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
          end
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid && !out_stall) begin
      got_count++;
      if (result_bytes_due.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no word pending", result_byte));
      end else begin
        want = result_bytes_due.pop_front();
        if (result_byte !== want)
          report_mismatch($sformatf("result_byte 0x%02h, expected 0x%02h", result_byte, want));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[three_register_nibble_stream_cipher] ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic [2:0] act, input logic [7:0] d, input logic [3:0] c);
    word_queue.push_back('{act, d, c});
  endtask

  task automatic push_random_word();
    int          r;
    int          rc;
    logic [2:0]  act;
    logic [7:0]  d;
    logic [3:0]  c;
    r = $urandom_range(0, 99);
    if (r < 5)       act = ACT_CLEAR;
    else if (r < 50) act = ACT_SHIFT;
    else if (r < 63) act = ACT_SECURE;
    else if (r < 78) act = ACT_ENCRYPT;
    else if (r < 92) act = ACT_DECRYPT;
    else             act = 3'($urandom_range(int'(ACT_DECRYPT) + 1, 7));
    rc = $urandom_range(0, 9);
    c = (rc == 0) ? 4'd0 : (rc < 3) ? 4'(MAX_REPEAT) : 4'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 1) ? 8'hff : 8'h00;
    else                           d = 8'($urandom_range(0, 255));
    push_word(act, d, c);
  endtask

  // sampled mid-cycle so that the driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (word_queue.size() != 0 || in_valid || result_bytes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_feedback(input logic v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FEEDBACK_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    fb_en = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[0] !== v) report_mismatch($sformatf("feedback_enable read %b", prdata[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int pushed;
    int k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // plain rounds first
    set_feedback(1'b0);
    push_word(ACT_CLEAR, 8'h00, 4'd0);
    push_word(ACT_SHIFT, 8'h00, 4'd0);
    push_word(ACT_SHIFT, 8'hff, 4'(MAX_REPEAT));
    push_word(ACT_SHIFT, 8'h01, 4'd1);
    push_word(ACT_SHIFT, 8'h80, 4'(MAX_REPEAT));
    push_word(ACT_SECURE, 8'hff, 4'hf);
    push_word(ACT_ENCRYPT, 8'h00, 4'd0);
    push_word(ACT_ENCRYPT, 8'hff, 4'd0);
    push_word(ACT_DECRYPT, 8'hff, 4'hf);
    push_word(ACT_DECRYPT, 8'h00, 4'd0);
    for (int a = int'(ACT_DECRYPT) + 1; a < 8; a++) push_word(3'(a), 8'h55, 4'd7);
    wait_drained();

    // output feedback
    set_feedback(1'b1);
    push_word(ACT_SHIFT, 8'ha5, 4'(MAX_REPEAT));
    push_word(ACT_SHIFT, 8'h5a, 4'd7);
    push_word(ACT_SECURE, 8'h00, 4'd0);
    push_word(ACT_ENCRYPT, 8'h3c, 4'd0);
    push_word(ACT_DECRYPT, 8'hc3, 4'd0);
    push_word(ACT_SHIFT, 8'hff, 4'd0);
    push_word(ACT_CLEAR, 8'hff, 4'hf);
    push_word(ACT_ENCRYPT, 8'h00, 4'd0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      set_feedback(1'(p % 2));
      pushed = 0;
      while (pushed < PHASE_WORDS) begin
        if ($urandom_range(0, 4) != 0) begin
          // session: clear, load key material, then cipher traffic
          push_word(ACT_CLEAR, 8'($urandom), 4'($urandom));
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++)
            push_word(ACT_SHIFT, 8'($urandom), 4'($urandom_range(1, MAX_REPEAT)));
          pushed += k + 1;
          k = $urandom_range(2, 10);
          for (int i = 0; i < k; i++) push_random_word();
          pushed += k;
        end else begin
          k = $urandom_range(1, 5);
          for (int i = 0; i < k; i++) push_random_word();
          pushed += k;
        end
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("[three_register_nibble_stream_cipher] OK");
    end else begin
      $display("[three_register_nibble_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
